>>> rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the sorted timer list
// Widths, command and status codes, and the controller-to-datapath bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  localparam int Nodes      = 64;
  localparam int IdxW       = $clog2(Nodes);
  localparam int LinkW      = IdxW + 1;
  localparam int KeyW       = 32;
  localparam int MaxResults = 64;

  localparam logic [LinkW-1:0] LinkNone = LinkW'(Nodes);

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdExpire = 2'd2;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StExpired = 2'd1;
  localparam logic [1:0] StNone    = 2'd2;
  localparam logic [1:0] StError   = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LATCH,      // capture input item, walk pointer to tail
    OP_RD_NODE,    // read key and links of walk node into read registers
    OP_RD_ENTRY,   // read links of entry being removed
    OP_EX_HEAD,    // entry and walk pointer take the current head
    OP_INS_EMPTY,  // insert into empty list
    OP_INS_AFTER1, // write entry key and links after walk node
    OP_INS_AFTER2, // next[node]=entry, fix prev[after] or tail
    OP_INS_HEAD1,  // write entry key and links as new head
    OP_INS_HEAD2,  // fix prev[old head], head=entry
    OP_UNLINK,     // fix next[lo] or head and prev[hi] or tail
    OP_STEP_PREV   // node = prev of read node
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             linked;     // linked flag of latched entry
    logic             key_le;     // read key <= latched key
    logic             prev_none;  // read node has no lower neighbour
    logic             head_none;
    logic             tail_none;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/stl_datapath.sv
// ----------------------------------------------------------------------------
// stl_datapath: link memories, key memory, head/tail and walk pointer
// Executes one controller operation per cycle; memories read registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stl_pkg::ctl_t               ctl,
  output stl_pkg::sts_t                    sts,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [stl_pkg::IdxW-1:0]    in_entry,
  input  wire logic [stl_pkg::KeyW-1:0]    in_key,
  output logic [stl_pkg::IdxW-1:0]         cur_entry,
  output logic [stl_pkg::KeyW-1:0]         rd_key_out
);
  import stl_pkg::*;

  logic [KeyW-1:0]  key_mem  [Nodes];
  logic [LinkW-1:0] next_mem [Nodes];
  logic [LinkW-1:0] prev_mem [Nodes];
  logic [Nodes-1:0] linked;
  logic [LinkW-1:0] head, tail, node;
  logic [1:0]       cmd;
  logic [IdxW-1:0]  ent;
  logic [KeyW-1:0]  key;
  logic [KeyW-1:0]  rd_key;
  logic [LinkW-1:0] rd_next, rd_prev;
  logic [IdxW-1:0]  rd_addr;
  logic             rd_en;

  // read address: walk node, or the entry itself for unlink
  always_comb begin
    rd_en   = (ctl.op == OP_RD_NODE) || (ctl.op == OP_RD_ENTRY);
    rd_addr = (ctl.op == OP_RD_ENTRY) ? ent : node[IdxW-1:0];
  end

  // registered memory read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  // at most one write per memory per cycle
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INS_EMPTY: begin
        key_mem[ent]  <= key;
        next_mem[ent] <= LinkNone;
        prev_mem[ent] <= LinkNone;
      end
      OP_INS_AFTER1: begin
        key_mem[ent]  <= key;
        next_mem[ent] <= rd_next;
        prev_mem[ent] <= node;
      end
      OP_INS_AFTER2: begin
        next_mem[node[IdxW-1:0]] <= {1'b0, ent};
        if (rd_next != LinkNone) prev_mem[rd_next[IdxW-1:0]] <= {1'b0, ent};
      end
      OP_INS_HEAD1: begin
        key_mem[ent]  <= key;
        next_mem[ent] <= head;
        prev_mem[ent] <= LinkNone;
      end
      OP_INS_HEAD2: begin
        if (head != LinkNone) prev_mem[head[IdxW-1:0]] <= {1'b0, ent};
      end
      OP_UNLINK: begin
        if (rd_prev != LinkNone) next_mem[rd_prev[IdxW-1:0]] <= rd_next;
        if (rd_next != LinkNone) prev_mem[rd_next[IdxW-1:0]] <= rd_prev;
      end
      default: ;
    endcase
  end

  // control registers: head, tail, walk pointer, flags, latched item
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= LinkNone;
      tail   <= LinkNone;
      node   <= LinkNone;
      linked <= '0;
      cmd    <= CmdInsert;
      ent    <= '0;
      key    <= '0;
    end else begin
      case (ctl.op)
        OP_LATCH: begin
          cmd  <= in_cmd;
          ent  <= in_entry;
          key  <= in_key;
          node <= tail;
        end
        OP_EX_HEAD: begin
          node <= head;
          ent  <= head[IdxW-1:0];
        end
        OP_INS_EMPTY: begin
          head <= {1'b0, ent};
          tail <= {1'b0, ent};
          linked[ent] <= 1'b1;
        end
        OP_INS_AFTER1: linked[ent] <= 1'b1;
        OP_INS_AFTER2: begin
          if (rd_next == LinkNone) tail <= {1'b0, ent};
        end
        OP_INS_HEAD1: linked[ent] <= 1'b1;
        OP_INS_HEAD2: begin
          if (head == LinkNone) tail <= {1'b0, ent};
          head <= {1'b0, ent};
        end
        OP_UNLINK: begin
          if (rd_prev == LinkNone) head <= rd_next;
          if (rd_next == LinkNone) tail <= rd_prev;
          linked[ent] <= 1'b0;
        end
        OP_STEP_PREV: node <= rd_prev;
        default: ;
      endcase
    end
  end

  // status back to the controller
  always_comb begin
    sts.cmd       = cmd;
    sts.linked    = linked[ent];
    sts.key_le    = $signed(rd_key) <= $signed(key);
    sts.prev_none = (rd_prev == LinkNone);
    sts.head_none = (head == LinkNone);
    sts.tail_none = (tail == LinkNone);
  end

  assign cur_entry  = ent;
  assign rd_key_out = rd_key;

endmodule

`default_nettype wire

>>> rtl/stl_ctrl.sv
// ----------------------------------------------------------------------------
// stl_ctrl: command sequencer for the sorted timer list
// Walks the list one node at a time, reading then comparing each node, and issues result items.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  output stl_pkg::ctl_t                  ctl,
  input  wire stl_pkg::sts_t             sts,
  input  wire logic [stl_pkg::IdxW-1:0]  cur_entry,
  input  wire logic [stl_pkg::KeyW-1:0]  rd_key,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [stl_pkg::IdxW-1:0]       o_entry,
  output logic [stl_pkg::KeyW-1:0]       o_key,
  output logic [1:0]                     o_status,
  output logic                           o_last
);
  import stl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_CMP, S_INS_A2, S_INS_H2,
    S_RM_UNL, S_EX_RD, S_EX_CMP, S_EX_LOAD, S_EX_HEAD
  } state_t;

  state_t            state;
  logic [LinkW-1:0]  walk;     // expired results staged so far
  logic              staged;   // an expired result waits in the output register
  logic              out_free;
  logic              ex_due;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign out_free = !m_tvalid || m_tready;
  assign ex_due   = sts.key_le && (walk < LinkW'(MaxResults));

  // operation decode per state
  always_comb begin
    ctl.op = OP_IDLE;
    case (state)
      S_IDLE: if (s_tvalid && s_tready) ctl.op = OP_LATCH;
      S_DECODE: begin
        case (sts.cmd)
          CmdInsert: if (!sts.linked && sts.tail_none) ctl.op = OP_INS_EMPTY;
          CmdRemove: if (sts.linked) ctl.op = OP_RD_ENTRY;
          CmdExpire: if (!sts.head_none) ctl.op = OP_EX_HEAD;
          default:   ctl.op = OP_IDLE;
        endcase
      end
      S_INS_RD: ctl.op = OP_RD_NODE;
      S_INS_CMP: begin
        if (sts.key_le) ctl.op = OP_INS_AFTER1;
        else if (sts.prev_none) ctl.op = OP_INS_HEAD1;
        else ctl.op = OP_STEP_PREV;
      end
      S_INS_A2:  ctl.op = OP_INS_AFTER2;
      S_INS_H2:  ctl.op = OP_INS_HEAD2;
      S_RM_UNL:  ctl.op = OP_UNLINK;
      S_EX_RD:   ctl.op = OP_RD_NODE;
      S_EX_LOAD: if (out_free) ctl.op = OP_UNLINK;
      S_EX_HEAD: if (!sts.head_none) ctl.op = OP_EX_HEAD;
      default:   ctl.op = OP_IDLE;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      walk     <= '0;
      staged   <= 1'b0;
      o_entry  <= '0;
      o_key    <= '0;
      o_status <= StDone;
      o_last   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          state <= S_DECODE;
        end
        S_DECODE: begin
          o_key   <= '0;
          o_entry <= cur_entry;
          o_last  <= 1'b1;
          walk    <= '0;
          staged  <= 1'b0;
          case (sts.cmd)
            CmdInsert: begin
              if (sts.linked) begin
                o_status <= StError; m_tvalid <= 1'b1; state <= S_IDLE;
              end else if (sts.tail_none) begin
                o_status <= StDone; m_tvalid <= 1'b1; state <= S_IDLE;
              end else state <= S_INS_RD;
            end
            CmdRemove: begin
              if (!sts.linked) begin
                o_status <= StError; m_tvalid <= 1'b1; state <= S_IDLE;
              end else state <= S_RM_UNL;
            end
            CmdExpire: begin
              if (sts.head_none) begin
                o_entry <= '0; o_status <= StNone; m_tvalid <= 1'b1; state <= S_IDLE;
              end else state <= S_EX_RD;
            end
            default: begin
              o_status <= StError; m_tvalid <= 1'b1; state <= S_IDLE;
            end
          endcase
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (sts.key_le) state <= S_INS_A2;
          else if (sts.prev_none) state <= S_INS_H2;
          else state <= S_INS_RD;
        end
        S_INS_A2: begin
          o_status <= StDone; m_tvalid <= 1'b1; state <= S_IDLE;
        end
        S_INS_H2: begin
          o_status <= StDone; m_tvalid <= 1'b1; state <= S_IDLE;
        end
        S_RM_UNL: begin
          o_status <= StDone; m_tvalid <= 1'b1; state <= S_IDLE;
        end
        S_EX_RD: state <= S_EX_CMP;
        S_EX_CMP: begin
          if (ex_due) begin
            // another entry is due, so the staged one is not the last
            if (staged) m_tvalid <= 1'b1;
            state <= S_EX_LOAD;
          end else if (staged) begin
            o_last <= 1'b1; m_tvalid <= 1'b1; state <= S_IDLE;
          end else begin
            o_entry <= '0; o_key <= '0; o_status <= StNone;
            o_last <= 1'b1; m_tvalid <= 1'b1; state <= S_IDLE;
          end
        end
        S_EX_LOAD: begin
          // previous result must be gone before a new one is staged
          if (out_free) begin
            o_entry  <= cur_entry;
            o_key    <= rd_key;
            o_status <= StExpired;
            o_last   <= 1'b0;
            staged   <= 1'b1;
            walk     <= walk + LinkW'(1);
            state    <= S_EX_HEAD;
          end
        end
        S_EX_HEAD: begin
          if (sts.head_none) begin
            o_last <= 1'b1; m_tvalid <= 1'b1; state <= S_IDLE;
          end else state <= S_EX_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_timer_list.sv
// For an error, an empty-list insert or an empty expire the result is set in the decode state after accept.
// Remove goes through decode and unlink; insert walks from the tail, reading and comparing one node at a time.
// Expire reads, compares, loads and unlinks each expired entry (at most 64), then reads the first later entry.
// One item at a time: the next is accepted once the final result has been taken.
// rst synchronously empties the list; keys and links are undefined until written.
// ----------------------------------------------------------------------------
// sorted_timer_list: ordered doubly linked timer list over a fixed pool
// Insert, remove and expire commands with one or more result items each.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_list (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // command[1:0], entry[7:2], key_or_time[39:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // out_entry[5:0], out_key[37:6], status[39:38]
  output logic             m_tlast   // last
);
  import stl_pkg::*;

  ctl_t            ctl;
  sts_t            sts;
  logic [IdxW-1:0] cur_entry;
  logic [KeyW-1:0] rd_key;
  logic [IdxW-1:0] o_entry;
  logic [KeyW-1:0] o_key;
  logic [1:0]      o_status;

  stl_datapath u_dp (
    .clk, .rst, .ctl, .sts,
    .in_cmd(s_tdata[1:0]), .in_entry(s_tdata[7:2]), .in_key(s_tdata[39:8]),
    .cur_entry, .rd_key_out(rd_key)
  );

  stl_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .ctl, .sts, .cur_entry,
    .rd_key, .m_tvalid, .m_tready, .o_entry, .o_key, .o_status, .o_last(m_tlast)
  );

  assign m_tdata = {o_status, o_key, o_entry};

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status != StExpired) |-> (o_key == '0))
    else $error("key set on non-expire result");
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (o_status == StDone || o_status == StError)) |-> m_tlast)
    else $error("single result without last");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while waiting");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted timer list
// Drives insert, remove and expire items with random gaps and back-pressure,
// predicts every result from a local copy of the list and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import stl_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  ent;
    logic [31:0] kt;
  } timer_cmd_t;

  typedef struct packed {
    logic [5:0]  ent;
    logic [31:0] key;
    logic [1:0]  status;
    logic        last;
  } timer_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  sorted_timer_list u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // shadow list state
  logic [31:0] key_mem  [Nodes];
  int          next_mem [Nodes];
  int          prev_mem [Nodes];
  bit          on_list  [Nodes];
  int          head_ptr = Nodes;
  int          tail_ptr = Nodes;

  timer_cmd_t  pending_cmds[$];
  timer_res_t  due_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          expired_seen = 0;
  int          cycles = 0;
  bit          hold_sender = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          took_item = 1'b0;
  int          hold_left = 0;

  function automatic bit key_le(logic [31:0] a, logic [31:0] b);
    return $signed(a) <= $signed(b);
  endfunction

  function automatic void unlink_node(int e);
    int hi;
    int lo;
    hi = next_mem[e];
    lo = prev_mem[e];
    if (lo < Nodes) next_mem[lo] = hi; else head_ptr = hi;
    if (hi < Nodes) prev_mem[hi] = lo; else tail_ptr = lo;
    next_mem[e] = Nodes;
    prev_mem[e] = Nodes;
    on_list[e] = 1'b0;
  endfunction

  function automatic void link_node(int e, logic [31:0] k);
    int node;
    int after;
    key_mem[e] = k;
    on_list[e] = 1'b1;
    node = tail_ptr;
    // walk down from the tail, equal keys stay ahead of the new entry
    while (node < Nodes) begin
      if (key_le(key_mem[node], k)) begin
        after = next_mem[node];
        next_mem[node] = e;
        prev_mem[e] = node;
        next_mem[e] = after;
        if (after < Nodes) prev_mem[after] = e; else tail_ptr = e;
        return;
      end
      node = prev_mem[node];
    end
    next_mem[e] = head_ptr;
    prev_mem[e] = Nodes;
    if (head_ptr < Nodes) prev_mem[head_ptr] = e; else tail_ptr = e;
    head_ptr = e;
  endfunction

  function automatic void predict_timer(timer_cmd_t c);
    int n;
    int h;
    timer_res_t r;
    n = 0;
    r = '{ent: c.ent, key: '0, status: StError, last: 1'b1};
    if (c.cmd == CmdInsert) begin
      if (!on_list[c.ent]) begin
        link_node(c.ent, c.kt);
        r.status = StDone;
      end
      due_results.push_back(r);
    end else if (c.cmd == CmdRemove) begin
      if (on_list[c.ent]) begin
        unlink_node(c.ent);
        r.status = StDone;
      end
      due_results.push_back(r);
    end else if (c.cmd == CmdExpire) begin
      while (n < MaxResults && head_ptr < Nodes && key_le(key_mem[head_ptr], c.kt)) begin
        h = head_ptr;
        due_results.push_back('{ent: h[5:0], key: key_mem[h], status: StExpired,
                                last: 1'b0});
        unlink_node(h);
        n++;
      end
      if (n == 0) due_results.push_back('{ent: '0, key: '0, status: StNone, last: 1'b1});
      else due_results[$].last = 1'b1;
    end else begin
      due_results.push_back(r);
    end
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] c, logic [5:0] e, logic [31:0] k);
    pending_cmds.push_back('{cmd: c, ent: e, kt: k});
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // input accept: predict at the accepting edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_timer(pending_cmds.pop_front());
      took_item = 1'b1;
    end
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (took_item) begin
        took_item = 1'b0;
        s_tvalid <= 1'b0;
        send_gap = gap_len();
      end else if (s_tvalid) begin
        // hold the offered item until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (!hold_sender && pending_cmds.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {pending_cmds[0].kt, pending_cmds[0].ent, pending_cmds[0].cmd};
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_res_t got;
    timer_res_t want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = '{ent: m_tdata[5:0], key: m_tdata[37:6], status: m_tdata[39:38],
              last: m_tlast};
      results_seen++;
      if (got.status == StExpired) expired_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: entry %0d/%0d key %h/%h status %0d/%0d last %0b/%0b",
                     want.ent, got.ent, want.key, got.key, want.status, got.status,
                     want.last, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", due_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_tvalid || due_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int e;
    int c;
    for (int i = 0; i < Nodes; i++) begin
      key_mem[i] = '0; next_mem[i] = Nodes; prev_mem[i] = Nodes; on_list[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty expire, extremes, equal keys, errors, unused code
    add_cmd(CmdExpire, 6'd0, 32'h7fff_ffff);
    add_cmd(CmdRemove, 6'd5, 32'd0);
    add_cmd(CmdInsert, 6'd0, 32'h8000_0000);
    add_cmd(CmdInsert, 6'd63, 32'h7fff_ffff);
    add_cmd(CmdInsert, 6'd0, 32'd1);
    add_cmd(CmdInsert, 6'd10, 32'd5);
    add_cmd(CmdInsert, 6'd11, 32'd5);
    add_cmd(CmdInsert, 6'd12, 32'hffff_fffb);
    add_cmd(CmdInsert, 6'd13, 32'd5);
    add_cmd(2'd3, 6'd42, 32'hffff_ffff);
    add_cmd(CmdRemove, 6'd11, 32'd0);
    add_cmd(CmdRemove, 6'd11, 32'd0);
    add_cmd(CmdExpire, 6'd0, 32'h8000_0000);
    add_cmd(CmdExpire, 6'd0, 32'd4);
    add_cmd(CmdExpire, 6'd0, 32'd5);
    add_cmd(CmdRemove, 6'd63, 32'd0);
    add_cmd(CmdExpire, 6'd0, 32'h7fff_ffff);
    wait_drained();

    // fill the pool while the receiver holds off, then expire all of it
    long_hold_req = 1'b1;
    for (int i = 0; i < Nodes; i++) add_cmd(CmdInsert, 6'(i), rand_key());
    add_cmd(CmdExpire, 6'd0, 32'h7fff_ffff);
    wait_drained();

    // sender held off after everything has come back
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    // random mix, mostly inserts with removes and expires in between
    for (int i = 0; i < 75; i++) begin
      c = $urandom_range(0, 9);
      e = $urandom_range(0, 63);
      if (c < 5) add_cmd(CmdInsert, 6'(e), rand_key());
      else if (c < 7) add_cmd(CmdRemove, 6'(e), $urandom);
      else if (c < 9) add_cmd(CmdExpire, 6'($urandom_range(0, 63)), rand_key());
      else add_cmd(2'($urandom_range(0, 3)), 6'(e), $urandom);
    end
    add_cmd(CmdExpire, 6'd0, 32'h7fff_ffff);
    wait_drained();
    repeat (300) @(posedge clk);

    $display("covered %0d result items, %0d of them expiries, incl. full pool",
             results_seen, expired_seen);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, due_results.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/stl_pkg.sv
rtl/stl_datapath.sv
rtl/stl_ctrl.sv
rtl/sorted_timer_list.sv
dv/testbench.sv
